>>> sv/keyframe_track_insert_lookup_core_assert.svh
// assertion macros for the keyframe track core
`ifndef KEYFRAME_TRACK_INSERT_LOOKUP_CORE_ASSERT_SVH
`define KEYFRAME_TRACK_INSERT_LOOKUP_CORE_ASSERT_SVH

// same-cycle implication
`define KTIL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KTIL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ktil_pkg.sv
// ---------------------------------------------------------------------------
// ktil_pkg
// shared types and constants of the keyframe track core
// ---------------------------------------------------------------------------
package ktil_pkg;

  localparam int TABLE_ENTRIES = 16384;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int KEY_LIMIT     = 10000;
  localparam int ALLOC_LIMIT   = (KEY_LIMIT < TABLE_ENTRIES) ? KEY_LIMIT : TABLE_ENTRIES;
  localparam int FRAME_W       = 32;
  localparam int MODE_W        = 8;
  localparam int IVL_W         = 32;
  localparam int DATA_W        = FRAME_W + MODE_W + IVL_W;

  localparam logic OP_LOOKUP   = 1'b0;
  localparam logic OP_REGISTER = 1'b1;

  typedef enum logic [1:0] {
    STAT_LOOKUP    = 2'd0,
    STAT_OVERWRITE = 2'd1,
    STAT_INSERT    = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DECIDE,
    S_HELD,
    S_WR1,
    S_WR2,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [MODE_W-1:0]    mode;
    logic [IVL_W-1:0]     interval;
    logic [IDX_W-1:0]     idx;
  } result_t;

endpackage

>>> sv/ktil_if.sv
// ---------------------------------------------------------------------------
// ktil_in_if / ktil_out_if
// request and result channels of the keyframe track core
// ---------------------------------------------------------------------------
interface ktil_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [ktil_pkg::FRAME_W-1:0]    frame;
  logic [ktil_pkg::MODE_W-1:0]     mode;
  logic [ktil_pkg::IVL_W-1:0]      interval;
  modport source (output valid, op, frame, mode, interval, input ready);
  modport sink   (input valid, op, frame, mode, interval, output ready);
endinterface

interface ktil_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [ktil_pkg::MODE_W-1:0]     mode_out;
  logic [ktil_pkg::IVL_W-1:0]      interval_out;
  logic [ktil_pkg::IDX_W-1:0]      entry_index;
  modport source (output valid, status, mode_out, interval_out, entry_index, input ready);
  modport sink   (input valid, status, mode_out, interval_out, entry_index, output ready);
endinterface

>>> sv/ktil_ram.sv
// ---------------------------------------------------------------------------
// ktil_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module ktil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ktil_seq.sv
// ---------------------------------------------------------------------------
// ktil_seq
// list walk, lookup and insert sequencer around the entry rams
// ---------------------------------------------------------------------------
module ktil_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           req_op,
  input  logic [ktil_pkg::FRAME_W-1:0]   req_frame,
  input  logic [ktil_pkg::MODE_W-1:0]    req_mode,
  input  logic [ktil_pkg::IVL_W-1:0]     req_interval,
  output logic                           res_valid,
  input  logic                           res_take,
  output ktil_pkg::result_t              res
);

  ktil_pkg::state_t st, st_next;

  logic                           op_q;
  logic [ktil_pkg::FRAME_W-1:0]   frame_q;
  logic [ktil_pkg::MODE_W-1:0]    mode_q;
  logic [ktil_pkg::IVL_W-1:0]     ivl_q;
  logic [ktil_pkg::IDX_W-1:0]     cand, cand_next;
  logic [ktil_pkg::IDX_W-1:0]     cur, cur_next;
  logic [ktil_pkg::FRAME_W-1:0]   cur_frame, cur_frame_next;
  logic [ktil_pkg::IDX_W-1:0]     cur_prev, cur_prev_next;
  logic [ktil_pkg::MODE_W-1:0]    cur_mode, cur_mode_next;
  logic [ktil_pkg::IVL_W-1:0]     cur_ivl, cur_ivl_next;
  logic                           ins_before, ins_before_next;
  logic [ktil_pkg::IDX_W-1:0]     head_next_idx, head_next_idx_next;
  logic [ktil_pkg::MODE_W-1:0]    head_mode, head_mode_next;
  logic [ktil_pkg::IVL_W-1:0]     head_ivl, head_ivl_next;
  logic [ktil_pkg::IDX_W-1:0]     count, count_next;
  ktil_pkg::result_t              res_next;

  // entry rams (head entry lives in flops)
  logic                           d_we, p_we, n_we;
  logic [ktil_pkg::IDX_W-1:0]     d_wa, p_wa, n_wa, raddr;
  logic [ktil_pkg::DATA_W-1:0]    d_wd, d_rd;
  logic [ktil_pkg::IDX_W-1:0]     p_wd, n_wd, p_rd, n_rd;
  logic [ktil_pkg::FRAME_W-1:0]   rd_frame;
  logic [ktil_pkg::MODE_W-1:0]    rd_mode;
  logic [ktil_pkg::IVL_W-1:0]     rd_ivl;
  logic                           full;

  ktil_ram #(.WIDTH(ktil_pkg::DATA_W), .DEPTH(ktil_pkg::TABLE_ENTRIES)) u_data (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(raddr), .rdata(d_rd));
  ktil_ram #(.WIDTH(ktil_pkg::IDX_W), .DEPTH(ktil_pkg::TABLE_ENTRIES)) u_prev (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(raddr), .rdata(p_rd));
  ktil_ram #(.WIDTH(ktil_pkg::IDX_W), .DEPTH(ktil_pkg::TABLE_ENTRIES)) u_next (
    .clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(raddr), .rdata(n_rd));

  assign {rd_frame, rd_mode, rd_ivl} = d_rd;
  assign full = (count >= ktil_pkg::IDX_W'(ktil_pkg::ALLOC_LIMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ktil_pkg::S_IDLE;
      head_next_idx <= '0;
      head_mode     <= '0;
      head_ivl      <= '0;
      count         <= ktil_pkg::IDX_W'(1);
    end else begin
      st            <= st_next;
      head_next_idx <= head_next_idx_next;
      head_mode     <= head_mode_next;
      head_ivl      <= head_ivl_next;
      count         <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op_q    <= req_op;
      frame_q <= req_frame;
      mode_q  <= req_mode;
      ivl_q   <= req_interval;
    end
    cand       <= cand_next;
    cur        <= cur_next;
    cur_frame  <= cur_frame_next;
    cur_prev   <= cur_prev_next;
    cur_mode   <= cur_mode_next;
    cur_ivl    <= cur_ivl_next;
    ins_before <= ins_before_next;
    res        <= res_next;
  end

  assign req_ready = (st == ktil_pkg::S_IDLE);
  assign res_valid = (st == ktil_pkg::S_DONE);

  always_comb begin
    st_next            = st;
    cand_next          = cand;
    cur_next           = cur;
    cur_frame_next     = cur_frame;
    cur_prev_next      = cur_prev;
    cur_mode_next      = cur_mode;
    cur_ivl_next       = cur_ivl;
    ins_before_next    = ins_before;
    head_next_idx_next = head_next_idx;
    head_mode_next     = head_mode;
    head_ivl_next      = head_ivl;
    count_next         = count;
    res_next           = res;
    raddr              = cand;
    d_we = 1'b0; d_wa = cur;   d_wd = {frame_q, mode_q, ivl_q};
    p_we = 1'b0; p_wa = count; p_wd = cur;
    n_we = 1'b0; n_wa = cur;   n_wd = count;

    case (st)
      ktil_pkg::S_IDLE: begin
        // start every walk at the head
        cur_next       = '0;
        cur_frame_next = '0;
        cur_prev_next  = '0;
        cur_mode_next  = head_mode;
        cur_ivl_next   = head_ivl;
        if (req_valid) begin
          if (req_frame != '0 && head_next_idx != '0) begin
            raddr     = head_next_idx;
            cand_next = head_next_idx;
            st_next   = ktil_pkg::S_WALK;
          end else begin
            st_next = ktil_pkg::S_DECIDE;
          end
        end
      end
      ktil_pkg::S_WALK: begin
        cur_next       = cand;
        cur_frame_next = rd_frame;
        cur_prev_next  = p_rd;
        cur_mode_next  = rd_mode;
        cur_ivl_next   = rd_ivl;
        if (rd_frame >= frame_q || n_rd == '0) begin
          st_next = ktil_pkg::S_DECIDE;
        end else begin
          raddr     = n_rd;
          cand_next = n_rd;
        end
      end
      ktil_pkg::S_DECIDE: begin
        if (op_q == ktil_pkg::OP_LOOKUP) begin
          if (cur_frame > frame_q) begin
            if (cur_prev == '0) begin
              res_next = '{ktil_pkg::STAT_LOOKUP, head_mode, head_ivl, '0};
              st_next  = ktil_pkg::S_DONE;
            end else begin
              raddr     = cur_prev;
              cand_next = cur_prev;
              st_next   = ktil_pkg::S_HELD;
            end
          end else begin
            res_next = '{ktil_pkg::STAT_LOOKUP, cur_mode, cur_ivl, cur};
            st_next  = ktil_pkg::S_DONE;
          end
        end else if (cur_frame == frame_q) begin
          if (cur == '0) begin
            head_mode_next = mode_q;
            head_ivl_next  = ivl_q;
          end else begin
            d_we = 1'b1;
          end
          res_next = '{ktil_pkg::STAT_OVERWRITE, '0, '0, cur};
          st_next  = ktil_pkg::S_DONE;
        end else if (full) begin
          res_next = '{ktil_pkg::STAT_FULL, '0, '0, '0};
          st_next  = ktil_pkg::S_DONE;
        end else begin
          ins_before_next = (cur_frame > frame_q);
          res_next        = '{ktil_pkg::STAT_INSERT, '0, '0, count};
          st_next         = ktil_pkg::S_WR1;
        end
      end
      ktil_pkg::S_HELD: begin
        res_next = '{ktil_pkg::STAT_LOOKUP, rd_mode, rd_ivl, cand};
        st_next  = ktil_pkg::S_DONE;
      end
      ktil_pkg::S_WR1: begin
        d_we = 1'b1;
        d_wa = count;
        if (ins_before) begin
          // predecessor points forward to the new entry, cur points back to it
          if (cur_prev == '0) begin
            head_next_idx_next = count;
          end else begin
            n_we = 1'b1;
            n_wa = cur_prev;
          end
          p_we = 1'b1;
          p_wa = cur;
          p_wd = count;
        end else begin
          if (cur == '0) begin
            head_next_idx_next = count;
          end else begin
            n_we = 1'b1;
          end
          p_we = 1'b1;
        end
        st_next = ktil_pkg::S_WR2;
      end
      ktil_pkg::S_WR2: begin
        n_we = 1'b1;
        n_wa = count;
        if (ins_before) begin
          n_wd = cur;
          p_we = 1'b1;
          p_wd = cur_prev;
        end else begin
          n_wd = '0;
        end
        count_next = count + ktil_pkg::IDX_W'(1);
        st_next    = ktil_pkg::S_DONE;
      end
      ktil_pkg::S_DONE: begin
        if (res_take) begin
          st_next = ktil_pkg::S_IDLE;
        end
      end
      default: st_next = ktil_pkg::S_IDLE;
    endcase
  end

endmodule

>>> sv/keyframe_track_insert_lookup_core.sv
// ---------------------------------------------------------------------------
// keyframe_track_insert_lookup_core
// frame-sorted keyframe list with lookup and register requests
// ---------------------------------------------------------------------------
// One request at a time. A request goes from idle through one walk state per
// list entry visited from the head (each visit is one registered read of the
// entry rams) to decide, then through a held state fetching the held key when
// a lookup steps back to an entry other than the head, or through the write
// states WR1 and WR2 for an insert, to done; the walk length is set by the
// number of keys ahead of the requested frame. The done state is held for as
// long as the output register keeps an untaken result. Free entries are handed
// out in order from index 1, so no clearing pass is needed after reset.
// The result sits in an output register while the next request is taken.
module keyframe_track_insert_lookup_core (
  input  logic        clk,
  input  logic        rst,
  ktil_in_if.sink     in_req,
  ktil_out_if.source  out_res
);

  `include "keyframe_track_insert_lookup_core_assert.svh"

  logic              res_valid;
  logic              res_take;
  ktil_pkg::result_t res;

  ktil_seq u_seq (
    .clk,
    .rst,
    .req_valid    (in_req.valid),
    .req_ready    (in_req.ready),
    .req_op       (in_req.op),
    .req_frame    (in_req.frame),
    .req_mode     (in_req.mode),
    .req_interval (in_req.interval),
    .res_valid,
    .res_take,
    .res
  );

  // output register
  logic              out_valid;
  ktil_pkg::result_t out_q;

  assign res_take = !out_valid || out_res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign out_res.valid        = out_valid;
  assign out_res.status       = out_q.status;
  assign out_res.mode_out     = out_q.mode;
  assign out_res.interval_out = out_q.interval;
  assign out_res.entry_index  = out_q.idx;

  `KTIL_ASSERT_NOW(a_ready_not_pending, clk, rst, in_req.ready, !res_valid, "request taken with result pending")
  `KTIL_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_req.valid && in_req.ready, !in_req.ready, "second request taken while busy")
  `KTIL_ASSERT_NOW(a_full_index, clk, rst, out_valid && out_q.status == ktil_pkg::STAT_FULL, out_q.idx == '0, "table full with nonzero index")

endmodule
